// ----- rtl/id_type_join_lookup_assert.svh -----
// assertion macros for the rtl, used by id_type_join_lookup
// expects clk and rst_n in the scope where a macro is used
`ifndef ID_TYPE_JOIN_LOOKUP_ASSERT_SVH
`define ID_TYPE_JOIN_LOOKUP_ASSERT_SVH

// checked on every clock edge outside reset
`define IDTJ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define IDTJ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/idtj_pkg.sv -----
// types and codes for the id/kind join lookup
// no dependencies
package idtj_pkg;

    localparam int ID_W    = 32;
    localparam int KIND_W  = 8;
    localparam int ENTRY_W = ID_W + KIND_W;
    localparam int MATCH_W = 10;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_CLEARED = 3'd2,
        ST_MATCH   = 3'd3,
        ST_NO_ID   = 3'd4,
        ST_NO_KIND = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [ID_W-1:0]   entry_id;
        logic [KIND_W-1:0]        entry_kind;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [MATCH_W-1:0]       match_index;
    } rsp_t;

endpackage

// ----- rtl/idtj_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module idtj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/id_type_join_lookup.sv -----
// top level of the id/kind join lookup: table load, clear and banked query scan
// depends on idtj_pkg, idtj_ram and id_type_join_lookup_assert.svh

// id_type_join_lookup keeps a table of up to TABLE_DEPTH (id, kind) entries and
// answers one response transaction per request transaction. A load appends an
// entry (status loaded, match_index = slot written) or, in a full table, is
// dropped with status full. A clear empties the table. A query
// returns the lowest slot whose id and kind both equal its own (status matched),
// status no-id when no slot has the id or the id is negative, and status
// id-without-kind when the id is there but never with that kind. match_index is
// the low 10 bits of the slot and 0 where it has no meaning. The table is spread
// over LANES ram banks with a write port and a read port each, slot i living
// in bank i mod LANES at row i / LANES. A query reads one row of all banks per
// cycle, stopping early when a match turns up; a negative id or an empty table
// is answered without a scan. The row read port sets the pace of the scan.
// Requests are taken only in idle with the response register free; a response
// still waiting there holds off the next request unless it is taken in that
// same cycle.
module id_type_join_lookup #(
    parameter int TABLE_DEPTH = 1024,
    parameter int LANES       = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  idtj_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output idtj_pkg::rsp_t rsp
);

    import idtj_pkg::*;

    localparam int ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RROW_W = $clog2(ROWS + 1);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TRK_W  = CNT_W + RROW_W;

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LANE_W-1:0]   wr_lane_reg, wr_lane_next;
    logic [RROW_W-1:0]   wr_row_reg, wr_row_next;
    logic [RROW_W-1:0]   rd_row_reg, rd_row_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_last_reg, s1_last_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                s2_last_reg, s2_last_next;
    logic                seen_reg, seen_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // payload
    logic [ID_W-1:0]     q_id_reg, q_id_next;
    logic [KIND_W-1:0]   q_kind_reg, q_kind_next;
    logic [RROW_W-1:0]   s1_row_reg, s1_row_next;
    logic [RROW_W-1:0]   s2_row_reg, s2_row_next;
    logic [LANES-1:0]    s2_hit_full_reg, s2_hit_full_next;
    logic [LANES-1:0]    s2_hit_id_reg, s2_hit_id_next;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    rsp_t                rsp_reg, rsp_next;

    // ram side
    logic [LANES-1:0]    bank_we;
    logic [ENTRY_W-1:0]  bank_wdata;
    logic [ENTRY_W-1:0]  bank_rdata [LANES];
    logic                issue;

    // helpers
    logic                accept;
    logic                out_free;
    logic                table_full;
    logic [RROW_W-1:0]   scan_rows;
    logic                issue_last;
    logic [LANE_W-1:0]   hit_lane;
    logic [IDX_W-1:0]    hit_index;
    logic [IDX_W+MATCH_W-1:0] res_index_ext;
    logic [IDX_W+MATCH_W-1:0] load_index_ext;

    // used by the checks only
    logic                kept_load;
    logic                in_scan;
    logic [CNT_W-1:0]    count_step;
    logic [TRK_W-1:0]    row_lane_slots;

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = req_valid && req_ready;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    // rows holding at least one valid slot
    assign scan_rows  = wr_row_reg + RROW_W'(wr_lane_reg != '0);
    assign issue_last = (rd_row_reg == scan_rows - RROW_W'(1));

    // loads land in bank wr_lane at row wr_row; a query can only start in a later
    // cycle, so the registered read never races a write to the same row
    assign bank_wdata = {req.entry_id, req.entry_kind};

    always_comb
    begin
        bank_we = '0;
        if (accept && (req.func == FUNC_LOAD) && !table_full)
        begin
            bank_we[wr_lane_reg] = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_bank
            idtj_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (ROWS)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we[g]),
                .waddr (wr_row_reg[ROW_W-1:0]),
                .wdata (bank_wdata),
                .re    (issue),
                .raddr (rd_row_reg[ROW_W-1:0]),
                .rdata (bank_rdata[g])
            );
        end
    endgenerate

    // stage 1: compare the returned row against the query, masking slots past count
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic lane_ok;
            logic id_eq;
            lane_ok = (s1_row_reg < wr_row_reg) || (LANE_W'(l) < wr_lane_reg);
            id_eq   = (bank_rdata[l][ENTRY_W-1:KIND_W] == q_id_reg);
            s2_hit_id_next[l]   = s1_valid_reg && lane_ok && id_eq;
            s2_hit_full_next[l] = s1_valid_reg && lane_ok && id_eq
                                  && (bank_rdata[l][KIND_W-1:0] == q_kind_reg);
        end
    end

    // stage 2: lowest matching lane
    always_comb
    begin
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (s2_hit_full_reg[l])
            begin
                hit_lane = LANE_W'(l);
            end
        end
    end

    assign hit_index = IDX_W'(s2_row_reg) * IDX_W'(LANES) + IDX_W'(hit_lane);

    assign res_index_ext  = {{MATCH_W{1'b0}}, res_index_reg};
    assign load_index_ext = {{MATCH_W{1'b0}}, count_reg[IDX_W-1:0]};

    // next state and outputs
    always_comb
    begin
        logic done;

        state_next      = state_reg;
        count_next      = count_reg;
        wr_lane_next    = wr_lane_reg;
        wr_row_next     = wr_row_reg;
        rd_row_next     = rd_row_reg;
        s1_valid_next   = 1'b0;
        s1_last_next    = 1'b0;
        s2_valid_next   = s1_valid_reg;
        s2_last_next    = s1_last_reg;
        seen_next       = seen_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        q_id_next       = q_id_reg;
        q_kind_next     = q_kind_reg;
        s1_row_next     = rd_row_reg;
        s2_row_next     = s1_row_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        rsp_next        = rsp_reg;
        issue           = 1'b0;
        done            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.match_index = '0;
                    rsp_next.status      = ST_NO_ID;
                    unique case (req.func)
                        FUNC_CLEAR:
                        begin
                            count_next      = '0;
                            wr_lane_next    = '0;
                            wr_row_next     = '0;
                            rsp_next.status = ST_CLEARED;
                        end
                        FUNC_LOAD:
                        begin
                            if (table_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                rsp_next.status      = ST_LOADED;
                                rsp_next.match_index = load_index_ext[MATCH_W-1:0];
                                count_next           = count_reg + CNT_W'(1);
                                if (wr_lane_reg == LANE_W'(LANES - 1))
                                begin
                                    wr_lane_next = '0;
                                    wr_row_next  = wr_row_reg + RROW_W'(1);
                                end
                                else
                                begin
                                    wr_lane_next = wr_lane_reg + LANE_W'(1);
                                end
                            end
                        end
                        FUNC_QUERY:
                        begin
                            // negative ids and an empty table answer at once
                            if (!req.entry_id[ID_W-1] && (count_reg != '0))
                            begin
                                rsp_valid_next = 1'b0;
                                q_id_next      = req.entry_id;
                                q_kind_next    = req.entry_kind;
                                rd_row_next    = '0;
                                seen_next      = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        FUNC_NOP:
                        begin
                            rsp_next.status = ST_NO_ID;
                        end
                        default:
                        begin
                            rsp_next.status = ST_NO_ID;
                        end
                    endcase
                end
            end

            S_SCAN, S_DRAIN:
            begin
                if (s2_valid_reg && (s2_hit_full_reg != '0))
                begin
                    done            = 1'b1;
                    res_status_next = ST_MATCH;
                    res_index_next  = hit_index;
                end
                else if (s2_valid_reg && s2_last_reg)
                begin
                    done            = 1'b1;
                    res_status_next = (seen_reg || (s2_hit_id_reg != '0)) ? ST_NO_KIND
                                                                          : ST_NO_ID;
                    res_index_next  = '0;
                end
                else if (s2_valid_reg)
                begin
                    seen_next = seen_reg || (s2_hit_id_reg != '0);
                end

                if (done)
                begin
                    // drop rows still in flight
                    s2_valid_next = 1'b0;
                    state_next    = S_WAIT_OUT;
                end
                else if (state_reg == S_SCAN)
                begin
                    issue         = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_last_next  = issue_last;
                    rd_row_next   = rd_row_reg + RROW_W'(1);
                    if (issue_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end

            S_WAIT_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_status_reg;
                    rsp_next.match_index = res_index_ext[MATCH_W-1:0];
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_lane_reg   <= '0;
            wr_row_reg    <= '0;
            rd_row_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_lane_reg   <= wr_lane_next;
            wr_row_reg    <= wr_row_next;
            rd_row_reg    <= rd_row_next;
            s1_valid_reg  <= s1_valid_next;
            s1_last_reg   <= s1_last_next;
            s2_valid_reg  <= s2_valid_next;
            s2_last_reg   <= s2_last_next;
            seen_reg      <= seen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_id_reg        <= q_id_next;
        q_kind_reg      <= q_kind_next;
        s1_row_reg      <= s1_row_next;
        s2_row_reg      <= s2_row_next;
        s2_hit_full_reg <= s2_hit_full_next;
        s2_hit_id_reg   <= s2_hit_id_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    assign kept_load      = accept && (req.func == FUNC_LOAD) && !table_full;
    assign in_scan        = (state_reg == S_SCAN) || (state_reg == S_DRAIN);
    assign count_step     = count_reg + CNT_W'(1);
    assign row_lane_slots = TRK_W'(wr_row_reg) * TRK_W'(LANES) + TRK_W'(wr_lane_reg);

    `include "id_type_join_lookup_assert.svh"

    `IDTJ_ASSERT(a_count_bound, (count_reg <= CNT_W'(TABLE_DEPTH)), "count past table depth")
    `IDTJ_ASSERT(a_row_lane_track, (row_lane_slots == TRK_W'(count_reg)), "row and lane off count")
    `IDTJ_ASSERT(a_pipe_in_scan, (s2_valid_reg |-> in_scan), "scan pipe busy outside a query")
    `IDTJ_ASSERT(a_load_counts, (kept_load |=> (count_reg == $past(count_step))), "load not counted")

endmodule

// ----- tb/sv/id_type_join_lookup_tb.sv -----
// self-checking testbench for id_type_join_lookup: table clear, load and query transactions
// depends on idtj_pkg and the id_type_join_lookup rtl; holds its own table scoreboard
module id_type_join_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idtj_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int LANES       = 64;
    // idle clocks after the last phase, to cover any job still in flight
    localparam int DRAIN_CYCLES = 40;

    // scoreboard: a copy of the lookup table plus the queue of responses it predicts
    class lookup_scoreboard;
        bit [ID_W-1:0]   table_ids   [TABLE_DEPTH];
        bit [KIND_W-1:0] table_kinds [TABLE_DEPTH];
        int              table_count = 0;
        rsp_t            expected_rsps [$];
        int              errors = 0;

        // work out the response of one accepted request and update the table copy
        function void add_request(req_t r);
            rsp_t want;
            bit   id_seen;
            bit   found;
            want = '0;
            want.status = ST_NO_ID;
            id_seen = 1'b0;
            found = 1'b0;
            case (r.func)
                FUNC_CLEAR:
                begin
                    table_count = 0;
                    want.status = ST_CLEARED;
                end
                FUNC_LOAD:
                begin
                    if (table_count < TABLE_DEPTH)
                    begin
                        table_ids[table_count] = r.entry_id;
                        table_kinds[table_count] = r.entry_kind;
                        want.match_index = table_count[MATCH_W-1:0];
                        want.status = ST_LOADED;
                        table_count++;
                    end
                    else
                    begin
                        want.status = ST_FULL;
                    end
                end
                FUNC_QUERY:
                begin
                    // a negative id never matches, whatever the table holds
                    if (!r.entry_id[ID_W-1])
                    begin
                        for (int i = 0; i < table_count && !found; i++)
                        begin
                            if (table_ids[i] == r.entry_id)
                            begin
                                if (table_kinds[i] == r.entry_kind)
                                begin
                                    want.status = ST_MATCH;
                                    want.match_index = i[MATCH_W-1:0];
                                    found = 1'b1;
                                end
                                id_seen = 1'b1;
                            end
                        end
                        if (!found && id_seen)
                            want.status = ST_NO_KIND;
                    end
                end
                default:
                begin
                    want.status = ST_NO_ID;
                end
            endcase
            expected_rsps.push_back(want);
        endfunction

        // compare one accepted response with the oldest prediction
        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response transaction: status %0d match_index %0d",
                       got.status, got.match_index);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.match_index !== want.match_index)
            begin
                $error("match_index: expected %0d, actual %0d",
                       want.match_index, got.match_index);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // idle and stall odds in percent, changed per phase
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    lookup_scoreboard sb = new();

    id_type_join_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LANES       (LANES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // response side: check each accepted transaction, then pick the next ready value
    // values read here are the ones from before the edge, since everything is driven by nba
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // present one request, with random idle cycles ahead of it, and wait for the handshake
    task automatic send_item(func_t f, logic [ID_W-1:0] id, logic [KIND_W-1:0] kind);
        req_t r;
        r.func = f;
        r.entry_id = id;
        r.entry_kind = kind;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.add_request(r);
    endtask

    // sender holds off until every predicted response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // ids from a narrow pool so that loads and queries collide often
    function automatic logic [ID_W-1:0] pool_id();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return $urandom_range(15);
        else if (pick < 90)
            return 32'h7FFF_FFF0 + $urandom_range(15);
        else
            return {1'b1, 31'($urandom_range(3))};
    endfunction

    // query mostly something that is in the table, sometimes a near miss
    task automatic send_query();
        int               pick;
        int               slot;
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99);
        if (sb.table_count > 0 && pick < 70)
        begin
            slot = $urandom_range(sb.table_count - 1);
            id = sb.table_ids[slot];
            // exact entry, or the same id with a kind that may not be there
            kind = (pick < 50) ? sb.table_kinds[slot] : 8'($urandom_range(3));
        end
        else if (pick < 90)
        begin
            id = pool_id();
            kind = 8'($urandom_range(3));
        end
        else
        begin
            id = {1'b1, 31'($urandom)};
            kind = 8'($urandom_range(255));
        end
        send_item(FUNC_QUERY, id, kind);
    endtask

    // random traffic: short load/query sequences broken up by clears and noise
    task automatic run_traffic(int n_items);
        int pick;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(func_t'($urandom_range(3)), $urandom, 8'($urandom_range(255)));
            else if (pick < 14)
                send_item(FUNC_CLEAR, $urandom, 8'($urandom_range(255)));
            else if (pick < 45)
                send_item(FUNC_LOAD, pool_id(), 8'($urandom_range(3)));
            else
                send_query();
        end
    endtask

    // fill every slot with a distinct id, overflow it, then query deep into it
    task automatic fill_table();
        int slot;
        send_item(FUNC_CLEAR, '0, '0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(FUNC_LOAD, 32'h0001_0000 + i, 8'(i) ^ 8'h5A);
        // table full: these are dropped
        send_item(FUNC_LOAD, 32'h0000_0003, 8'h01);
        send_item(FUNC_LOAD, 32'hFFFF_FFFF, 8'hFF);
        send_item(FUNC_LOAD, 32'h0001_0000, 8'h5A);
        // last slot, first slot, a wrong kind, an absent id, then random ones
        send_item(FUNC_QUERY, 32'h0001_0000 + TABLE_DEPTH - 1, 8'(TABLE_DEPTH - 1) ^ 8'h5A);
        send_item(FUNC_QUERY, 32'h0001_0000, 8'h5A);
        send_item(FUNC_QUERY, 32'h0001_0000 + TABLE_DEPTH - 1, 8'h00);
        send_item(FUNC_QUERY, 32'h0000_0003, 8'h01);
        for (int i = 0; i < 30; i++)
        begin
            slot = $urandom_range(TABLE_DEPTH - 1);
            if ($urandom_range(3) == 0)
                send_item(FUNC_QUERY, 32'h0001_0000 + slot, 8'($urandom_range(255)));
            else
                send_item(FUNC_QUERY, 32'h0001_0000 + slot, 8'(slot) ^ 8'h5A);
        end
        send_item(FUNC_CLEAR, '0, '0);
        send_item(FUNC_QUERY, 32'h0001_0000, 8'h5A);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every func, and the corner cases
        send_item(FUNC_QUERY, 32'd5, 8'd0);              // empty table
        send_item(FUNC_NOP, 32'hA5A5_A5A5, 8'hC3);       // unused func code
        send_item(FUNC_LOAD, 32'h7FFF_FFFF, 8'hFF);
        send_item(FUNC_LOAD, 32'h0000_0000, 8'h00);
        send_item(FUNC_LOAD, 32'hFFFF_FFFF, 8'h00);      // negative stored id
        send_item(FUNC_LOAD, 32'h8000_0000, 8'hFF);
        send_item(FUNC_LOAD, 32'd7, 8'd1);
        send_item(FUNC_LOAD, 32'd7, 8'd2);
        send_item(FUNC_LOAD, 32'd7, 8'd1);               // duplicate, lowest slot must win
        send_item(FUNC_QUERY, 32'h7FFF_FFFF, 8'hFF);
        send_item(FUNC_QUERY, 32'h0000_0000, 8'h00);
        send_item(FUNC_QUERY, 32'hFFFF_FFFF, 8'h00);     // negative query id
        send_item(FUNC_QUERY, 32'h8000_0000, 8'hFF);
        send_item(FUNC_QUERY, 32'd7, 8'd1);
        send_item(FUNC_QUERY, 32'd7, 8'd2);
        send_item(FUNC_QUERY, 32'd7, 8'd3);              // id there, kind missing
        send_item(FUNC_QUERY, 32'd8, 8'd1);              // id missing
        send_item(FUNC_QUERY, 32'h7FFF_FFFF, 8'hFE);
        send_item(FUNC_NOP, 32'd7, 8'd1);
        send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        send_item(FUNC_QUERY, 32'd7, 8'd1);              // gone after clear
        send_item(FUNC_LOAD, 32'h5555_5555, 8'hAA);
        send_item(FUNC_QUERY, 32'h5555_5555, 8'hAA);

        // phase with no idling, including the full table run
        fill_table();
        run_traffic(120);
        wait_drained();

        // sender idles
        send_idle_pct = 58;
        run_traffic(130);
        wait_drained();

        // receiver stalls
        send_idle_pct = 0;
        rsp_stall_pct = 58;
        run_traffic(130);
        wait_drained();

        // both sides
        send_idle_pct = 25;
        rsp_stall_pct = 25;
        run_traffic(130);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("id_type_join_lookup_tb OK");
        else
            $display("id_type_join_lookup_tb NOT OK");
        $finish;
    end

    // hang guard
    initial
    begin
        #10ms;
        $display("id_type_join_lookup_tb NOT OK");
        $finish;
    end

endmodule
